[rtl/eyxz_pkg.sv]
package eyxz_pkg;

   // Build constants.
   localparam int CORDIC_STEPS  = 16;
   localparam int OUT_FRAC_BITS = 16;
   localparam int CORDIC_N      = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

   // Internal widths: trig values, angles and rotation entries.
   localparam int CW = 34;
   localparam int AW = 36;

   // Divider geometry: quotient bits, bits per stage, remainder width.
   localparam int QW         = 44;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = QW / DIV_BITS;
   localparam int RW         = 17;

   // Output alignment shifts.
   localparam int MODEL_SH  = 38 - OUT_FRAC_BITS;
   localparam int NORMAL_SH = 30 - OUT_FRAC_BITS;
   localparam int TR_LSH    = (OUT_FRAC_BITS >= 16) ? OUT_FRAC_BITS - 16 : 0;
   localparam int TR_RSH    = (OUT_FRAC_BITS >= 16) ? 0 : 16 - OUT_FRAC_BITS;

   localparam logic signed [AW-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [AW-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [AW-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [CW-1:0] Q30_GAIN    = 34'sh026DD3B6A;

   localparam logic [1:0] LAST_COLUMN = 2'd3;

   // Per item side data that rides along the trig pipeline.
   typedef struct packed {
      logic [2:0][15:0] scale;
      logic [2:0][31:0] shift;
   } side_type;

   // Per column data that rides along the divider.
   typedef struct packed {
      logic [1:0]       col;
      logic             scale_zero;
      logic [2:0]       q_neg;
      logic [2:0]       r_pos;
      logic [2:0]       r_neg;
      logic [15:0]      d_mag;
      logic [2:0][51:0] model_prod;
      logic [2:0][31:0] trans;
   } col_meta_type;

   // Truncated Q30 arctangent of 2^-i.
   function automatic logic signed [AW-1:0] atan_entry(input int i);
      logic [31:0] v;
      case (i)
         0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;   2: v = 32'h0FADBAFC;
         3: v = 32'h07F56EA6;   4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
         6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;   8: v = 32'h003FFFEA;
         9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF;  16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
        18: v = 32'h00000FFF;  19: v = 32'h000007FF;  20: v = 32'h000003FF;
        21: v = 32'h000001FF;  22: v = 32'h000000FF;  23: v = 32'h0000007F;
        24: v = 32'h0000003F;  25: v = 32'h0000001F;  26: v = 32'h0000000F;
        27: v = 32'h00000008;  28: v = 32'h00000004;  29: v = 32'h00000002;
        30: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      return $signed({4'b0, v});
   endfunction

   // Q30 product, rounded toward minus infinity.
   function automatic logic signed [AW-1:0] mul30(input logic signed [AW-1:0] a,
                                                   input logic signed [AW-1:0] b);
      logic signed [2*AW-1:0] p;
      p = a * b;
      return p[AW+29:30];
   endfunction

   // Saturate to 32 bits signed.
   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

endpackage

[rtl/euler_yxz_transform_matrix_unit.sv]
// Path: input, two-pi wrap, half-pi fold, CORDIC stages, trig fix-up, first products,
// triple products, rotation entries, serialiser, column setup, divider stages and
// output register. Inputs are spaced out, set by the four column items that follow
// in column order and share the single result channel. A stalled result freezes the whole pipeline.
// Reset: synchronous, active high; clears all valid bits and the input spacing
// counter, leaving the pipeline empty and ready.
module euler_yxz_transform_matrix_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_angle_x,
   input  logic signed [15:0] req_angle_y,
   input  logic signed [15:0] req_angle_z,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [15:0] req_scale_z,
   input  logic signed [31:0] req_shift_x,
   input  logic signed [31:0] req_shift_y,
   input  logic signed [31:0] req_shift_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_column_index,
   output logic signed [31:0] rsp_model_row0,
   output logic signed [31:0] rsp_model_row1,
   output logic signed [31:0] rsp_model_row2,
   output logic signed [31:0] rsp_normal_row0,
   output logic signed [31:0] rsp_normal_row1,
   output logic signed [31:0] rsp_normal_row2,
   output logic               rsp_final_column
);
   import eyxz_pkg::*;

   logic adv;
   logic req_fire;
   logic [1:0] gap_ff;

   // Input stage.
   logic                 s0_v_ff;
   logic signed [15:0]   s0_ang_ff [3];
   side_type             s0_side_ff;
   // Two-pi wrap.
   logic                 s1_v_ff;
   logic signed [AW-1:0] s1_ang_ff [3];
   side_type             s1_side_ff;
   // Half-pi fold.
   logic                 s2_v_ff;
   logic signed [AW-1:0] s2_ang_ff [3];
   logic [2:0]           s2_neg_ff;
   side_type             s2_side_ff;
   // CORDIC stages.
   logic                 cv_ff   [CORDIC_N];
   logic signed [CW-1:0] cx_ff   [CORDIC_N][3];
   logic signed [CW-1:0] cy_ff   [CORDIC_N][3];
   logic signed [AW-1:0] cz_ff   [CORDIC_N][3];
   logic [2:0]           cneg_ff [CORDIC_N];
   side_type             cside_ff[CORDIC_N];
   // Signed trig values; lane 0 is x (s2,c2), 1 is y (s1,c1), 2 is z (s3,c3).
   logic                 t_v_ff;
   logic signed [AW-1:0] t_s_ff [3];
   logic signed [AW-1:0] t_c_ff [3];
   side_type             t_side_ff;
   // First products.
   logic                 p1_v_ff;
   logic signed [AW-1:0] p1_c1c3_ff, p1_s1s2_ff, p1_c1s2_ff, p1_c3s1_ff, p1_c1s3_ff;
   logic signed [AW-1:0] p1_s1s3_ff, p1_c2s3_ff, p1_c2c3_ff, p1_c2s1_ff, p1_c1c2_ff;
   logic signed [AW-1:0] p1_s2_ff, p1_s3_ff;
   side_type             p1_side_ff;
   // Triple products.
   logic                 p2_v_ff;
   logic signed [AW-1:0] p2_ta_ff, p2_tb_ff, p2_tc_ff, p2_td_ff;
   logic signed [AW-1:0] p2_c1c3_ff, p2_c3s1_ff, p2_c1s3_ff, p2_s1s3_ff;
   logic signed [AW-1:0] p2_c2s3_ff, p2_c2c3_ff, p2_c2s1_ff, p2_c1c2_ff, p2_s2_ff;
   side_type             p2_side_ff;
   // Rotation entries, index column*3+row.
   logic                 r_v_ff;
   logic signed [AW-1:0] r_rot_ff [9];
   side_type             r_side_ff;
   // Column serialiser.
   logic                 ser_v_ff;
   logic [1:0]           ser_col_ff;
   logic signed [AW-1:0] ser_rot_ff [9];
   side_type             ser_side_ff;
   // Column setup and divider.
   logic                 b0_v_ff;
   logic [QW-1:0]        b0_num_ff [3];
   col_meta_type         b0_meta_ff;
   logic                 dv_ff   [DIV_STAGES];
   logic [QW-1:0]        dn_ff   [DIV_STAGES][3];
   logic [RW-1:0]        dr_ff   [DIV_STAGES][3];
   col_meta_type         dmeta_ff[DIV_STAGES];
   // Output register.
   logic                 out_v_ff;
   logic [1:0]           out_col_ff;
   logic [31:0]          out_model_ff  [3];
   logic [31:0]          out_normal_ff [3];

   // The pipeline moves whenever the output register can take a new item.
   assign adv       = !out_v_ff || rsp_ready;
   assign req_ready = adv && (gap_ff == 2'd3);
   assign req_fire  = req_valid && req_ready;

   // Inputs are spaced apart in advancing cycles by this counter so columns never collide.
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= 2'd3;
      end else if (adv) begin
         if (req_fire) gap_ff <= 2'd0;
         else if (gap_ff != 2'd3) gap_ff <= gap_ff + 2'd1;
      end
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         for (int k = 0; k < CORDIC_N; k++) cv_ff[k] <= 1'b0;
         t_v_ff   <= 1'b0;
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         r_v_ff   <= 1'b0;
         ser_v_ff <= 1'b0;
         ser_col_ff <= 2'd0;
         b0_v_ff  <= 1'b0;
         for (int k = 0; k < DIV_STAGES; k++) dv_ff[k] <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_fire;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         cv_ff[0] <= s2_v_ff;
         for (int k = 1; k < CORDIC_N; k++) cv_ff[k] <= cv_ff[k-1];
         t_v_ff  <= cv_ff[CORDIC_N-1];
         p1_v_ff <= t_v_ff;
         p2_v_ff <= p1_v_ff;
         r_v_ff  <= p2_v_ff;
         if (r_v_ff) begin
            ser_v_ff   <= 1'b1;
            ser_col_ff <= 2'd0;
         end else if (ser_v_ff && ser_col_ff != LAST_COLUMN) begin
            ser_col_ff <= ser_col_ff + 2'd1;
         end else begin
            ser_v_ff <= 1'b0;
         end
         b0_v_ff  <= ser_v_ff;
         dv_ff[0] <= b0_v_ff;
         for (int k = 1; k < DIV_STAGES; k++) dv_ff[k] <= dv_ff[k-1];
         out_v_ff <= dv_ff[DIV_STAGES-1];
      end
   end

   // Input capture, angle reduction and CORDIC.
   always_ff @(posedge clock) begin
      logic signed [AW-1:0] a;
      logic signed [CW-1:0] xi, yi;
      logic signed [AW-1:0] zi;
      if (adv) begin
         s0_ang_ff[0] <= req_angle_x;
         s0_ang_ff[1] <= req_angle_y;
         s0_ang_ff[2] <= req_angle_z;
         s0_side_ff.scale <= {req_scale_z, req_scale_y, req_scale_x};
         s0_side_ff.shift <= {req_shift_z, req_shift_y, req_shift_x};

         for (int l = 0; l < 3; l++) begin
            a = AW'(s0_ang_ff[l]) <<< 18;
            if (a > Q30_PI) a = a - Q30_TWO_PI;
            if (a > Q30_PI) a = a - Q30_TWO_PI;
            if (a < -Q30_PI) a = a + Q30_TWO_PI;
            if (a < -Q30_PI) a = a + Q30_TWO_PI;
            s1_ang_ff[l] <= a;
         end
         s1_side_ff <= s0_side_ff;

         for (int l = 0; l < 3; l++) begin
            if (s1_ang_ff[l] > Q30_HALF_PI) begin
               s2_ang_ff[l] <= s1_ang_ff[l] - Q30_PI;
               s2_neg_ff[l] <= 1'b1;
            end else if (s1_ang_ff[l] < -Q30_HALF_PI) begin
               s2_ang_ff[l] <= s1_ang_ff[l] + Q30_PI;
               s2_neg_ff[l] <= 1'b1;
            end else begin
               s2_ang_ff[l] <= s1_ang_ff[l];
               s2_neg_ff[l] <= 1'b0;
            end
         end
         s2_side_ff <= s1_side_ff;

         // One micro-rotation per stage, three lanes side by side.
         for (int k = 0; k < CORDIC_N; k++) begin
            for (int l = 0; l < 3; l++) begin
               if (k == 0) begin
                  xi = Q30_GAIN;
                  yi = '0;
                  zi = s2_ang_ff[l];
               end else begin
                  xi = cx_ff[k-1][l];
                  yi = cy_ff[k-1][l];
                  zi = cz_ff[k-1][l];
               end
               if (zi >= 0) begin
                  cx_ff[k][l] <= xi - (yi >>> k);
                  cy_ff[k][l] <= yi + (xi >>> k);
                  cz_ff[k][l] <= zi - atan_entry(k);
               end else begin
                  cx_ff[k][l] <= xi + (yi >>> k);
                  cy_ff[k][l] <= yi - (xi >>> k);
                  cz_ff[k][l] <= zi + atan_entry(k);
               end
            end
            if (k == 0) begin
               cneg_ff[k]  <= s2_neg_ff;
               cside_ff[k] <= s2_side_ff;
            end else begin
               cneg_ff[k]  <= cneg_ff[k-1];
               cside_ff[k] <= cside_ff[k-1];
            end
         end
      end
   end

   // Trig sign fix-up, products and rotation entries.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            if (cneg_ff[CORDIC_N-1][l]) begin
               t_s_ff[l] <= -AW'(cy_ff[CORDIC_N-1][l]);
               t_c_ff[l] <= -AW'(cx_ff[CORDIC_N-1][l]);
            end else begin
               t_s_ff[l] <= AW'(cy_ff[CORDIC_N-1][l]);
               t_c_ff[l] <= AW'(cx_ff[CORDIC_N-1][l]);
            end
         end
         t_side_ff <= cside_ff[CORDIC_N-1];

         p1_c1c3_ff <= mul30(t_c_ff[1], t_c_ff[2]);
         p1_s1s2_ff <= mul30(t_s_ff[1], t_s_ff[0]);
         p1_c1s2_ff <= mul30(t_c_ff[1], t_s_ff[0]);
         p1_c3s1_ff <= mul30(t_c_ff[2], t_s_ff[1]);
         p1_c1s3_ff <= mul30(t_c_ff[1], t_s_ff[2]);
         p1_s1s3_ff <= mul30(t_s_ff[1], t_s_ff[2]);
         p1_c2s3_ff <= mul30(t_c_ff[0], t_s_ff[2]);
         p1_c2c3_ff <= mul30(t_c_ff[0], t_c_ff[2]);
         p1_c2s1_ff <= mul30(t_c_ff[0], t_s_ff[1]);
         p1_c1c2_ff <= mul30(t_c_ff[1], t_c_ff[0]);
         p1_s2_ff   <= t_s_ff[0];
         p1_s3_ff   <= t_s_ff[2];
         p1_side_ff <= t_side_ff;

         p2_ta_ff   <= mul30(p1_s1s2_ff, p1_s3_ff);
         p2_tb_ff   <= mul30(p1_c1s2_ff, p1_s3_ff);
         p2_tc_ff   <= mul30(p1_c3s1_ff, p1_s2_ff);
         p2_td_ff   <= mul30(p1_c1c3_ff, p1_s2_ff);
         p2_c1c3_ff <= p1_c1c3_ff;
         p2_c3s1_ff <= p1_c3s1_ff;
         p2_c1s3_ff <= p1_c1s3_ff;
         p2_s1s3_ff <= p1_s1s3_ff;
         p2_c2s3_ff <= p1_c2s3_ff;
         p2_c2c3_ff <= p1_c2c3_ff;
         p2_c2s1_ff <= p1_c2s1_ff;
         p2_c1c2_ff <= p1_c1c2_ff;
         p2_s2_ff   <= p1_s2_ff;
         p2_side_ff <= p1_side_ff;

         r_rot_ff[0] <= p2_c1c3_ff + p2_ta_ff;
         r_rot_ff[1] <= p2_c2s3_ff;
         r_rot_ff[2] <= p2_tb_ff - p2_c3s1_ff;
         r_rot_ff[3] <= p2_tc_ff - p2_c1s3_ff;
         r_rot_ff[4] <= p2_c2c3_ff;
         r_rot_ff[5] <= p2_td_ff + p2_s1s3_ff;
         r_rot_ff[6] <= p2_c2s1_ff;
         r_rot_ff[7] <= -p2_s2_ff;
         r_rot_ff[8] <= p2_c1c2_ff;
         r_side_ff   <= p2_side_ff;

         // The serialiser holds an item for its four columns.
         if (r_v_ff) begin
            ser_rot_ff  <= r_rot_ff;
            ser_side_ff <= r_side_ff;
         end
      end
   end

   // Column setup: model products, divider operands and translation.
   always_ff @(posedge clock) begin
      logic signed [AW-1:0] r;
      logic signed [15:0]   sc;
      logic signed [QW-1:0] n;
      logic signed [63:0]   t64;
      logic [1:0]           ci;
      if (adv) begin
         ci = (ser_col_ff == LAST_COLUMN) ? 2'd0 : ser_col_ff;
         sc = $signed(ser_side_ff.scale[ci]);
         b0_meta_ff.col        <= ser_col_ff;
         b0_meta_ff.scale_zero <= (sc == 16'sd0);
         b0_meta_ff.d_mag      <= sc[15] ? 16'(-sc) : 16'(sc);
         for (int row = 0; row < 3; row++) begin
            r = ser_rot_ff[ci*3 + row];
            n = QW'(r) <<< 8;
            b0_meta_ff.model_prod[row] <= 52'(r * sc);
            b0_meta_ff.q_neg[row]      <= n[QW-1] ^ sc[15];
            b0_meta_ff.r_pos[row]      <= (r > 0);
            b0_meta_ff.r_neg[row]      <= r[AW-1];
            b0_num_ff[row]             <= n[QW-1] ? QW'(-n) : QW'(n);
            t64 = 64'($signed(ser_side_ff.shift[row]));
            if (OUT_FRAC_BITS >= 16) b0_meta_ff.trans[row] <= sat32(t64 <<< TR_LSH);
            else                     b0_meta_ff.trans[row] <= sat32(t64 >>> TR_RSH);
         end
      end
   end

   // Restoring divider, four quotient bits per stage.
   always_ff @(posedge clock) begin
      logic [QW-1:0] num;
      logic [RW-1:0] rem;
      col_meta_type  m;
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            m = (k == 0) ? b0_meta_ff : dmeta_ff[k-1];
            for (int row = 0; row < 3; row++) begin
               if (k == 0) begin
                  num = b0_num_ff[row];
                  rem = '0;
               end else begin
                  num = dn_ff[k-1][row];
                  rem = dr_ff[k-1][row];
               end
               for (int j = 0; j < DIV_BITS; j++) begin
                  rem = {rem[RW-2:0], num[QW-1]};
                  num = {num[QW-2:0], 1'b0};
                  if (rem >= {1'b0, m.d_mag}) begin
                     rem    = rem - {1'b0, m.d_mag};
                     num[0] = 1'b1;
                  end
               end
               dn_ff[k][row] <= num;
               dr_ff[k][row] <= rem;
            end
            dmeta_ff[k] <= m;
         end
      end
   end

   // Final alignment, saturation and the output register.
   always_ff @(posedge clock) begin
      col_meta_type         m;
      logic signed [QW:0]   q;
      logic signed [51:0]   mp;
      if (adv) begin
         m = dmeta_ff[DIV_STAGES-1];
         out_col_ff <= m.col;
         for (int row = 0; row < 3; row++) begin
            q  = m.q_neg[row] ? -$signed({1'b0, dn_ff[DIV_STAGES-1][row]})
                              :  $signed({1'b0, dn_ff[DIV_STAGES-1][row]});
            mp = $signed(m.model_prod[row]);
            if (m.col == LAST_COLUMN) begin
               out_model_ff[row]  <= m.trans[row];
               out_normal_ff[row] <= '0;
            end else begin
               out_model_ff[row] <= sat32(64'(mp >>> MODEL_SH));
               if (m.scale_zero) begin
                  if (m.r_pos[row])      out_normal_ff[row] <= 32'h7FFFFFFF;
                  else if (m.r_neg[row]) out_normal_ff[row] <= 32'h80000000;
                  else                   out_normal_ff[row] <= '0;
               end else begin
                  out_normal_ff[row] <= sat32(64'(q >>> NORMAL_SH));
               end
            end
         end
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_column_index = out_col_ff;
   assign rsp_model_row0   = $signed(out_model_ff[0]);
   assign rsp_model_row1   = $signed(out_model_ff[1]);
   assign rsp_model_row2   = $signed(out_model_ff[2]);
   assign rsp_normal_row0  = $signed(out_normal_ff[0]);
   assign rsp_normal_row1  = $signed(out_normal_ff[1]);
   assign rsp_normal_row2  = $signed(out_normal_ff[2]);
   assign rsp_final_column = (out_col_ff == LAST_COLUMN);

endmodule
